@@ rtl/lru_pkg.sv @@
// Shared types, codes and field widths for the LRU recency list.
`default_nettype none

package lru_pkg;

  // Field widths fixed by the stream format
  localparam int ACT_W      = 2;
  localparam int KEY_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int RANK_W     = 4;
  localparam int CAP_W      = 5;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  // Capacity after reset and the longest list that is ever emitted
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int               LIST_MAX  = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_VISIT  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_EVICT   = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_ENTRY   = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  // What every cell does with its key this cycle
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_FRONT,
    SHIFT_CLOSE
  } shift_e;

  typedef struct packed {
    shift_e op;
    logic   fill_all;  // miss: whole row moves back by one
  } lru_cmd_t;

  typedef enum logic {
    LRU_IDLE,
    LRU_LIST
  } lru_state_e;

endpackage

`default_nettype wire

@@ rtl/lru_cell.sv @@
// One position of the recency row: key register, compare and neighbour shift.
`default_nettype none

module lru_cell #(
  parameter int INDEX    = 0,
  parameter int KEY_BITS = 64,
  parameter int CNT_W    = 5,
  parameter int SEL_W    = 5
) (
  input  wire                 clk_i,
  input  wire lru_pkg::lru_cmd_t cmd_i,
  input  wire  [KEY_BITS-1:0] key_i,
  input  wire  [CNT_W-1:0]    cnt_i,
  input  wire  [SEL_W-1:0]    sel_i,
  input  wire  [KEY_BITS-1:0] left_key_i,
  input  wire  [KEY_BITS-1:0] right_key_i,
  input  wire                 after_hit_i,   // match somewhere behind this cell
  input  wire                 before_hit_i,  // match somewhere in front of it
  input  wire  [KEY_BITS-1:0] pick_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                after_hit_o,
  output logic                before_hit_o,
  output logic [KEY_BITS-1:0] pick_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                occupied;
  logic                match;

  assign occupied = CNT_W'(INDEX) < cnt_i;
  assign match    = occupied && (key_q == key_i);

  // Match flags ripple both ways along the row
  assign after_hit_o  = after_hit_i | match;
  assign before_hit_o = before_hit_i | match;

  // Selected key ripples towards the head
  assign pick_o = (sel_i == SEL_W'(INDEX)) ? key_q : pick_i;
  assign key_o  = key_q;

  always_comb begin
    key_d = key_q;
    unique case (cmd_i.op)
      lru_pkg::SHIFT_FRONT: begin
        if (cmd_i.fill_all || after_hit_i || match) key_d = left_key_i;
      end
      lru_pkg::SHIFT_CLOSE: begin
        if (before_hit_i || match) key_d = right_key_i;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

@@ rtl/lru_chain.sv @@
// Row of recency cells, most recent at position 0, with the ripple links.
`default_nettype none

module lru_chain #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 64,
  parameter int CNT_W    = 5,
  parameter int SEL_W    = 5
) (
  input  wire                 clk_i,
  input  wire lru_pkg::lru_cmd_t cmd_i,
  input  wire  [KEY_BITS-1:0] key_i,
  input  wire  [CNT_W-1:0]    cnt_i,
  input  wire  [SEL_W-1:0]    sel_i,
  output logic                found_o,
  output logic [KEY_BITS-1:0] pick_o
);

  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [KEY_BITS-1:0] pick       [DEPTH+1];
  logic                hit_behind [DEPTH+1];
  logic                hit_ahead  [DEPTH+1];

  assign hit_behind[DEPTH] = 1'b0;
  assign hit_ahead[0]      = 1'b0;
  assign pick[DEPTH]       = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic [KEY_BITS-1:0] right_key;

    // Head takes the incoming key, tail refills from itself
    if (i == 0) begin : g_head
      assign left_key = key_i;
    end else begin : g_body
      assign left_key = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    lru_cell #(
      .INDEX    (i),
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .SEL_W    (SEL_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd_i),
      .key_i        (key_i),
      .cnt_i        (cnt_i),
      .sel_i        (sel_i),
      .left_key_i   (left_key),
      .right_key_i  (right_key),
      .after_hit_i  (hit_behind[i+1]),
      .before_hit_i (hit_ahead[i]),
      .pick_i       (pick[i+1]),
      .key_o        (cell_key[i]),
      .after_hit_o  (hit_behind[i]),
      .before_hit_o (hit_ahead[i+1]),
      .pick_o       (pick[i])
    );
  end

  assign found_o = hit_behind[0];
  assign pick_o  = pick[0];

endmodule

`default_nettype wire

@@ rtl/lru_recency_list.sv @@
// Top level of the LRU recency list: stream ports, control and result register.
`default_nettype none

// Keeps up to "capacity" keys (clamped to 1..DEPTH) in recency order in a row of
// DEPTH cells, each comparing its key with the incoming one and shifting from a
// neighbour in the same cycle. Input beat: tuser = action (0 visit, 1 remove,
// 2 list), tdata = key (only the low KEY_BITS bits count). A visit or remove
// gives one result beat; action 3 is consumed with no result. A list of n
// entries (n = min(count, capacity, 16)) takes the request, then gives one
// beat per cycle while the sink takes them; an empty list gives one beat.
// No input is taken until the last beat has been loaded, and a result beat held
// by the sink holds off both input and list. The clock period is set by the
// match and select ripple along the DEPTH cells. Lowering capacity below the
// stored count keeps the entries until the next miss, which trims the row and
// reports the least recent key.
module lru_recency_list #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 64
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Configuration: capacity
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [lru_pkg::CAP_W-1:0]       cfg_data_i,
  // Input stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [lru_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [63:0] key
  input  wire  [lru_pkg::ACT_W-1:0]       s_axis_tuser,   // [1:0] action
  // Result stream
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [lru_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [63:0] key_out, [67:64] rank
  output logic [lru_pkg::STATUS_W-1:0]    m_axis_tuser,   // [2:0] status
  output logic                            m_axis_tlast    // last
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RW     = lru_pkg::RANK_W;
  localparam int SEL_W  = (CNT_W > RW) ? CNT_W : RW;
  localparam int CMP_W  = (CNT_W > lru_pkg::CAP_W) ? CNT_W : lru_pkg::CAP_W;
  localparam int KW     = lru_pkg::KEY_W;
  localparam int PAD_W  = lru_pkg::OUT_DATA_W - KW - RW;

  // Registers
  lru_pkg::lru_state_e       state_q, state_d;
  logic [lru_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [RW-1:0]             rank_q, rank_d;
  logic [RW-1:0]             last_rank_q, last_rank_d;
  logic                      out_valid_q, out_valid_d;
  lru_pkg::status_e          status_q, status_d;
  logic [KW-1:0]             key_out_q, key_out_d;
  logic [RW-1:0]             out_rank_q, out_rank_d;
  logic                      out_last_q, out_last_d;

  logic                      out_free;
  logic                      in_acc;
  lru_pkg::action_e          act;
  logic [KEY_BITS-1:0]       key_in;
  logic [CMP_W-1:0]          cap_w, eff_cap, cnt_w, list_n;
  lru_pkg::lru_cmd_t         cmd;
  logic [SEL_W-1:0]          sel;
  logic                      found;
  logic [KEY_BITS-1:0]       picked;

  assign cfg_ready_o = 1'b1;

  // Handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == lru_pkg::LRU_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign act           = lru_pkg::action_e'(s_axis_tuser);
  assign key_in        = s_axis_tdata[KEY_BITS-1:0];

  // Effective capacity and list length
  assign cap_w = CMP_W'(cap_q);
  assign cnt_w = CMP_W'(count_q);
  always_comb begin
    eff_cap = cap_w;
    if (cap_w == '0) eff_cap = CMP_W'(1);
    if (cap_w > CMP_W'(DEPTH)) eff_cap = CMP_W'(DEPTH);
    list_n = (cnt_w < eff_cap) ? cnt_w : eff_cap;
    if (list_n > CMP_W'(lru_pkg::LIST_MAX)) list_n = CMP_W'(lru_pkg::LIST_MAX);
  end

  // Cell row selection: list entry while listing, tail otherwise
  assign sel = (state_q == lru_pkg::LRU_LIST) ? SEL_W'(rank_q) : SEL_W'(count_q - 1'b1);

  lru_chain #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W),
    .SEL_W    (SEL_W)
  ) u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .key_i   (key_in),
    .cnt_i   (count_q),
    .sel_i   (sel),
    .found_o (found),
    .pick_o  (picked)
  );

  // Next state, cell command and result beat
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rank_d       = rank_q;
    last_rank_d  = last_rank_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    status_d     = status_q;
    key_out_d    = key_out_q;
    out_rank_d   = out_rank_q;
    out_last_d   = out_last_q;
    cmd.op       = lru_pkg::SHIFT_HOLD;
    cmd.fill_all = 1'b0;

    unique case (state_q)
      lru_pkg::LRU_IDLE: begin
        if (in_acc) begin
          out_rank_d = '0;
          out_last_d = 1'b1;
          key_out_d  = KW'(key_in);
          unique case (act)
            lru_pkg::ACT_VISIT: begin
              out_valid_d  = 1'b1;
              cmd.op       = lru_pkg::SHIFT_FRONT;
              cmd.fill_all = !found;
              if (found) begin
                status_d = lru_pkg::ST_HIT;
              end else if (cnt_w >= eff_cap) begin
                status_d  = lru_pkg::ST_EVICT;
                key_out_d = KW'(picked);
                count_d   = CNT_W'(eff_cap);
              end else begin
                status_d = lru_pkg::ST_MISS;
                count_d  = count_q + 1'b1;
              end
            end
            lru_pkg::ACT_REMOVE: begin
              out_valid_d = 1'b1;
              if (found) begin
                cmd.op   = lru_pkg::SHIFT_CLOSE;
                status_d = lru_pkg::ST_REMOVED;
                count_d  = count_q - 1'b1;
              end else begin
                status_d = lru_pkg::ST_ABSENT;
              end
            end
            lru_pkg::ACT_LIST: begin
              if (list_n == '0) begin
                out_valid_d = 1'b1;
                status_d    = lru_pkg::ST_EMPTY;
                key_out_d   = '0;
              end else begin
                state_d     = lru_pkg::LRU_LIST;
                rank_d      = '0;
                last_rank_d = RW'(list_n - 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      lru_pkg::LRU_LIST: begin
        // One entry per free slot of the result register
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = lru_pkg::ST_ENTRY;
          key_out_d   = KW'(picked);
          out_rank_d  = rank_q;
          out_last_d  = (rank_q == last_rank_q);
          rank_d      = rank_q + 1'b1;
          if (rank_q == last_rank_q) state_d = lru_pkg::LRU_IDLE;
        end
      end
      default: state_d = lru_pkg::LRU_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lru_pkg::LRU_IDLE;
      cap_q       <= lru_pkg::CAP_RESET;
      count_q     <= '0;
      rank_q      <= '0;
      last_rank_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rank_q      <= rank_d;
      last_rank_q <= last_rank_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    key_out_q  <= key_out_d;
    out_rank_q <= out_rank_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_rank_q, key_out_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_list_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lru_pkg::LRU_LIST) |-> !s_axis_tready)
    else $error("input taken while listing");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (act == lru_pkg::ACT_VISIT) && found) |=> (count_q == $past(count_q)))
    else $error("hit changed entry count");

  a_list_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lru_pkg::LRU_LIST) && out_free) |=> m_axis_tvalid)
    else $error("list entry not presented");

endmodule

`default_nettype wire

@@ bench/tb_lru_recency_list.sv @@
// Self-checking testbench for the LRU recency list: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_lru_recency_list;
  import lru_pkg::*;

  localparam int DEPTH       = 16;
  localparam int POOL_SIZE   = 24;
  localparam int WAIT_MAX    = 17;
  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 31;

  // Action code the block consumes without any result
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
  } lru_req_t;

  typedef struct {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
    logic              last;
  } lru_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [63:0] key
  logic [ACT_W-1:0]      s_axis_tuser = '0;   // [1:0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [63:0] key_out, [67:64] rank
  logic [STATUS_W-1:0]   m_axis_tuser;   // [2:0] status
  logic                  m_axis_tlast;

  // Predictor state: keys in recency order, fill level and capacity register
  logic [KEY_W-1:0] model_keys [DEPTH];
  int unsigned      model_count = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  lru_beat_t        due_results [$];
  lru_req_t         pending_reqs [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // Handshake flags from the last rising edge
  bit in_fire, out_fire, cfg_taken;

  // Driver and sink pacing
  bit          src_calm, snk_calm;
  bit          have_cur;
  lru_req_t    cur_req;
  int unsigned wait_left, stall_left;

  // Bookkeeping
  int unsigned items_queued, items_taken, beats_checked, cap_writes;
  int unsigned fail_count, idle_cycles;
  int unsigned status_seen [7];

  lru_recency_list #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Capacity as the block applies it: at least one, at most the row depth
  function automatic int unsigned eff_capacity();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void expect_beat(status_e st, logic [KEY_W-1:0] key,
                                      int unsigned rank, bit last);
    lru_beat_t b;
    b.status = st;
    b.key    = key;
    b.rank   = RANK_W'(rank);
    b.last   = last;
    due_results.push_back(b);
  endfunction

  // Shift positions 0..pos-1 back by one and put key at the front
  function automatic void move_to_front(int unsigned pos, logic [KEY_W-1:0] key);
    int unsigned p;
    p = (pos >= DEPTH) ? DEPTH - 1 : pos;
    for (int i = p; i > 0; i--) model_keys[i] = model_keys[i-1];
    model_keys[0] = key;
  endfunction

  // Work out the result beats of one accepted request and update the order
  function automatic void recency_update(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key);
    int unsigned      cap, n, pos;
    bit               hit;
    logic [KEY_W-1:0] evicted;
    cap = eff_capacity();
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < model_count && i < DEPTH; i++) begin
      if (!hit && model_keys[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    case (act)
      ACT_VISIT: begin
        if (hit) begin
          move_to_front(pos, key);
          expect_beat(ST_HIT, key, 0, 1'b1);
        end else if (model_count >= cap) begin
          // full, or capacity lowered: trim the tail, report its oldest key
          evicted     = model_keys[model_count-1];
          model_count = cap - 1;
          move_to_front(model_count, key);
          model_count++;
          expect_beat(ST_EVICT, evicted, 0, 1'b1);
        end else begin
          move_to_front(model_count, key);
          model_count++;
          expect_beat(ST_MISS, key, 0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          expect_beat(ST_ABSENT, key, 0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
          expect_beat(ST_REMOVED, key, 0, 1'b1);
        end
      end
      ACT_LIST: begin
        n = model_count;
        if (n > cap) n = cap;
        if (n > LIST_MAX) n = LIST_MAX;
        if (n == 0) expect_beat(ST_EMPTY, '0, 0, 1'b1);
        for (int i = 0; i < n; i++) expect_beat(ST_ENTRY, model_keys[i], i, i + 1 == n);
      end
      default: ;
    endcase
  endfunction

  // Compare one result beat with the oldest expectation
  function automatic void check_beat();
    lru_beat_t want;
    beats_checked++;
    if (m_axis_tuser < 7) status_seen[m_axis_tuser]++;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t: unexpected beat status %0d key %h rank %0d last %0b", $realtime,
                 m_axis_tuser, m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W+:RANK_W],
                 m_axis_tlast);
      return;
    end
    want = due_results.pop_front();
    if (m_axis_tuser !== want.status || m_axis_tdata[KEY_W-1:0] !== want.key ||
        m_axis_tdata[KEY_W+:RANK_W] !== want.rank || m_axis_tlast !== want.last) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("%0t: beat mismatch: want st %0d key %h rank %0d last %0b", $realtime,
                 want.status, want.key, want.rank, want.last);
        $display("%0t:                got  st %0d key %h rank %0d last %0b", $realtime,
                 m_axis_tuser, m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W+:RANK_W],
                 m_axis_tlast);
      end
    end
  endfunction

  // Wait before a beat; calm phases run back to back
  function automatic int unsigned draw_wait(bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, WAIT_MAX) : 0;
  endfunction

  // Monitor: handshakes, prediction, checking and the stall watchdog
  always @(posedge clk_i) begin
    in_fire   = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire  = rst_ni && m_axis_tvalid && m_axis_tready;
    cfg_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    if (cfg_taken) begin
      cap_reg = cfg_data_i;
      cap_writes++;
    end
    if (in_fire) begin
      items_taken++;
      recency_update(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
    end
    if (out_fire) check_beat();
    idle_cycles = (in_fire || out_fire || cfg_taken || !rst_ni) ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $realtime,
               idle_cycles, due_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Request driver, fed from the pending queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !in_fire)) begin
      if (!have_cur && pending_reqs.size() != 0) begin
        cur_req   = pending_reqs.pop_front();
        have_cur  = 1'b1;
        wait_left = draw_wait(src_calm);
      end
      if (have_cur && wait_left == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur_req.key;
        s_axis_tuser  <= cur_req.action;
        have_cur = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_cur) wait_left--;
      end
    end
  end

  // Result sink: ready held until a beat moves, then a fresh stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!(m_axis_tready && !out_fire)) begin
      if (m_axis_tready) stall_left = draw_wait(snk_calm);
      if (stall_left == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  task automatic queue_req(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key);
    lru_req_t r;
    r.action = act;
    r.key    = key;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // Let every request and result pass, then the list latency
  task automatic drain();
    while (items_taken != items_queued || due_results.size() != 0) @(negedge clk_i);
    repeat (LIST_MAX + 4) @(negedge clk_i);
  endtask

  // Capacity write, only issued with the block idle and at a falling edge
  task automatic set_capacity(logic [CAP_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly keys from a pool a little larger than the capacity, so hits,
  // evictions and full lists are common; a few fresh keys and spare actions
  task automatic random_phase(int unsigned count);
    int unsigned      taken, span, roll;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    taken = 0;
    span  = eff_capacity() + 3;
    if (span > POOL_SIZE) span = POOL_SIZE;
    while (taken < count) begin
      roll = $urandom_range(0, 99);
      key  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(0, span - 1)];
      if (roll < 55)      act = ACT_VISIT;
      else if (roll < 78) act = ACT_REMOVE;
      else if (roll < 95) act = ACT_LIST;
      else                act = ACT_SPARE;
      queue_req(act, key);
      if (act != ACT_SPARE) taken++;
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [CAP_W-1:0] cap_plan [8];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    cap_plan = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17,
                 5'($urandom_range(1, 16))};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, key extremes, hit, remove, spare action
    src_calm = 1'b1;
    snk_calm = 1'b1;
    queue_req(ACT_LIST, '0);
    queue_req(ACT_REMOVE, key_pool[5]);
    queue_req(ACT_VISIT, '0);
    queue_req(ACT_VISIT, '1);
    queue_req(ACT_VISIT, '0);
    queue_req(ACT_LIST, '0);
    queue_req(ACT_REMOVE, '1);
    queue_req(ACT_SPARE, '1);
    for (int i = 1; i <= 3; i++) queue_req(ACT_VISIT, key_pool[i]);
    drain();

    // Capacity lowered below the fill level: hit on a kept tail entry,
    // short list, then a miss that trims the row
    set_capacity(5'd2);
    queue_req(ACT_VISIT, '0);
    queue_req(ACT_LIST, '0);
    queue_req(ACT_VISIT, key_pool[4]);
    queue_req(ACT_LIST, '0);
    drain();

    // Capacity zero behaves as one
    set_capacity(5'd0);
    queue_req(ACT_VISIT, key_pool[5]);
    queue_req(ACT_VISIT, key_pool[5]);
    queue_req(ACT_LIST, '0);
    queue_req(ACT_REMOVE, key_pool[5]);
    queue_req(ACT_LIST, '0);
    drain();

    // Random phases over a spread of capacities and pacing modes
    foreach (cap_plan[p]) begin
      set_capacity(cap_plan[p]);
      src_calm = (p == 2) || (p == 6);
      snk_calm = (p == 4) || (p == 6);
      random_phase(PHASE_ITEMS);
      drain();
    end

    $display("%0d requests sent, %0d result beats checked, %0d capacity writes",
             items_taken, beats_checked, cap_writes);
    $display("hit %0d  miss %0d  evict %0d  removed %0d  absent %0d  listed %0d  empty %0d",
             status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_EVICT],
             status_seen[ST_REMOVED], status_seen[ST_ABSENT], status_seen[ST_ENTRY],
             status_seen[ST_EMPTY]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failing beats", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lru_pkg.sv
rtl/lru_cell.sv
rtl/lru_chain.sv
rtl/lru_recency_list.sv
bench/tb_lru_recency_list.sv
